### rtl/eul_pkg.sv
// Shared constants and types for the Euler x-y-z rotation matrix core.
`timescale 1ns / 1ps
`default_nettype none

package eul_pkg;

    localparam int ANGLE_W    = 12;
    localparam int OUT_W      = 16;
    localparam int ANGLE_BITS = 12;
    localparam int FRAC_BITS  = 14;

    // quarter-wave sine table: entries 0..QUARTER inclusive
    localparam int QUARTER   = 1 << (ANGLE_BITS - 2);
    localparam int ADDR_W    = ANGLE_BITS - 1;
    localparam int ROM_DEPTH = 1 << ADDR_W;

    localparam int VAL_W  = FRAC_BITS + 2;
    localparam int PROD_W = 2 * FRAC_BITS + 2;
    localparam int SUM_W  = FRAC_BITS + 3;
    localparam int WIDE_W = (SUM_W > OUT_W) ? SUM_W : OUT_W;

    localparam int OQ_DEPTH = 8;
    localparam int OQ_PTR_W = 3;
    localparam int OQ_CNT_W = OQ_PTR_W + 1;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              neg;
    } trig_ref_t;

    typedef struct packed {
        trig_ref_t sx;
        trig_ref_t cx;
        trig_ref_t sy;
        trig_ref_t cy;
        trig_ref_t sz;
        trig_ref_t cz;
    } trig_req_t;

    typedef struct packed {
        logic [OUT_W-1:0] r00;
        logic [OUT_W-1:0] r01;
        logic [OUT_W-1:0] r02;
        logic [OUT_W-1:0] r10;
        logic [OUT_W-1:0] r11;
        logic [OUT_W-1:0] r12;
        logic [OUT_W-1:0] r20;
        logic [OUT_W-1:0] r21;
        logic [OUT_W-1:0] r22;
    } result_t;

endpackage

`default_nettype wire

### rtl/eul_sine_rom.sv
// Quarter-wave sine ROM with two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module eul_sine_rom
    import eul_pkg::*;
(
    input  wire logic                clk,
    input  wire logic [ADDR_W-1:0]   addr_a,
    input  wire logic [ADDR_W-1:0]   addr_b,
    output logic      [FRAC_BITS:0]  data_a,
    output logic      [FRAC_BITS:0]  data_b
);

    typedef logic [FRAC_BITS:0] sine_table_t [ROM_DEPTH];

    localparam logic [63:0] HalfPiQ61 = 64'h3243F6A8885A308D;
    localparam logic [63:0] StepQ61   = HalfPiQ61 / QUARTER;
    localparam logic [63:0] RestQ61   = HalfPiQ61 % QUARTER;

    // (a * b) >> 61 on unsigned Q2.61, low 64 bits kept
    function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[124:61];
    endfunction

    // floor(a / d) by shift and subtract, d nonzero
    function automatic logic [63:0] div_u64(input logic [63:0] a, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], a[b]};
            if (r >= {1'b0, d})
            begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Taylor series of sin(x) on Q2.61, rounded to FRAC_BITS; evaluated at elaboration
    function automatic sine_table_t build_sine_table();
        sine_table_t tbl;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] dv;
        for (int j = 0; j < ROM_DEPTH; j++)
        begin
            tbl[j] = '0;
            if (j <= QUARTER)
            begin
                x    = StepQ61 * 64'(j) + (RestQ61 * 64'(j)) / QUARTER;
                x2   = mul_q61(x, x);
                term = x;
                sum  = x;
                for (int n = 1; n < 40 && term != 64'd0; n++)
                begin
                    dv   = 64'(2 * n) * 64'(2 * n + 1);
                    term = div_u64(mul_q61(term, x2), dv);
                    if (n[0])
                        sum = sum - term;
                    else
                        sum = sum + term;
                end
                sum    = (sum + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS);
                tbl[j] = sum[FRAC_BITS:0];
            end
        end
        return tbl;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

    always_ff @(posedge clk)
    begin
        data_a <= SINE_TABLE[addr_a];
        data_b <= SINE_TABLE[addr_b];
    end

endmodule

`default_nettype wire

### rtl/eul_front.sv
// Front end: takes angle requests, folds them to table addresses and signs, small queue.
`timescale 1ns / 1ps
`default_nettype none

module eul_front
    import eul_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [ANGLE_W-1:0] angle_x,
    input  wire logic [ANGLE_W-1:0] angle_y,
    input  wire logic [ANGLE_W-1:0] angle_z,
    output logic                    req_valid,
    output trig_req_t               req,
    input  wire logic               req_take
);

    // quadrant fold: odd quadrants mirror the index, upper half negates
    function automatic trig_ref_t fold(input logic [ANGLE_BITS-1:0] k);
        trig_ref_t         r;
        logic [ADDR_W-1:0] j;
        j      = ADDR_W'(k[ANGLE_BITS-3:0]);
        r.addr = k[ANGLE_BITS-2] ? (ADDR_W'(QUARTER) - j) : j;
        r.neg  = k[ANGLE_BITS-1];
        return r;
    endfunction

    function automatic trig_ref_t fold_cos(input logic [ANGLE_BITS-1:0] k);
        return fold(k + ANGLE_BITS'(QUARTER));
    endfunction

    trig_req_t  entry;
    trig_req_t  q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;

    always_comb
    begin
        entry.sx = fold(ANGLE_BITS'(angle_x));
        entry.cx = fold_cos(ANGLE_BITS'(angle_x));
        entry.sy = fold(ANGLE_BITS'(angle_y));
        entry.cy = fold_cos(ANGLE_BITS'(angle_y));
        entry.sz = fold(ANGLE_BITS'(angle_z));
        entry.cz = fold_cos(ANGLE_BITS'(angle_z));
    end

    assign full      = (cnt_reg == 2'd2);
    assign req_valid = (cnt_reg != 2'd0);
    assign req       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = req_take ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, req_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= entry;
    end

endmodule

`default_nettype wire

### rtl/eul_back.sv
// Back end: table lookups, two multiplier ranks, sums with saturation, result queue.
`timescale 1ns / 1ps
`default_nettype none

module eul_back
    import eul_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    input  wire trig_req_t req,
    output logic           req_take,
    output logic           empty,
    input  wire logic      pop,
    output result_t        res
);

    localparam int CREDIT_W = OQ_CNT_W + 1;
    localparam logic signed [SUM_W-1:0] ONE_SUM = SUM_W'(64'd1 << FRAC_BITS);

    typedef logic signed [VAL_W-1:0]  val_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    // floor(p / 2^FRAC_BITS)
    function automatic val_t shr(input prod_t p);
        prod_t s;
        s = p >>> FRAC_BITS;
        return s[VAL_W-1:0];
    endfunction

    function automatic sum_t ext(input val_t v);
        return SUM_W'(v);
    endfunction

    function automatic logic [OUT_W-1:0] to_field(input sum_t v);
        sum_t                     s;
        logic signed [WIDE_W-1:0] w;
        if (v > ONE_SUM)
            s = ONE_SUM;
        else if (v < -ONE_SUM)
            s = -ONE_SUM;
        else
            s = v;
        w = WIDE_W'(s);
        return w[OUT_W-1:0];
    endfunction

    function automatic val_t apply_sign(input logic [FRAC_BITS:0] d, input logic neg);
        val_t v;
        v = $signed({1'b0, d});
        return neg ? -v : v;
    endfunction

    // ---- lookup stage ----
    logic [FRAC_BITS:0] d_sx, d_cx, d_sy, d_cy, d_sz, d_cz;
    logic [5:0]         neg_reg;

    eul_sine_rom u_rom_x (
        .clk    (clk),
        .addr_a (req.sx.addr),
        .addr_b (req.cx.addr),
        .data_a (d_sx),
        .data_b (d_cx)
    );

    eul_sine_rom u_rom_y (
        .clk    (clk),
        .addr_a (req.sy.addr),
        .addr_b (req.cy.addr),
        .data_a (d_sy),
        .data_b (d_cy)
    );

    eul_sine_rom u_rom_z (
        .clk    (clk),
        .addr_a (req.sz.addr),
        .addr_b (req.cz.addr),
        .data_a (d_sz),
        .data_b (d_cz)
    );

    // ---- datapath registers ----
    val_t  sx1_reg, cx1_reg, sy1_reg, cy1_reg, sz1_reg, cz1_reg;
    val_t  sx2_reg, cx2_reg, sy2_reg;
    prod_t p_cycz_reg, p_cysz_reg, p_cxsz_reg, p_cxcz_reg, p_sxcy_reg;
    prod_t p_sxsz_reg, p_sxcz_reg, p_cxcy_reg, p_t1_reg, p_t2_reg;
    val_t  sx3_reg, cx3_reg, t1_reg, t2_reg;
    val_t  a00_3_reg, a01_3_reg, a02_3_reg, a10_3_reg, a11_3_reg;
    val_t  a12_3_reg, a20_3_reg, a21_3_reg, a22_3_reg;
    prod_t q10_reg, q11_reg, q20_reg, q21_reg;
    val_t  a00_4_reg, a01_4_reg, a02_4_reg, a10_4_reg, a11_4_reg;
    val_t  a12_4_reg, a20_4_reg, a21_4_reg, a22_4_reg;

    always_ff @(posedge clk)
    begin
        neg_reg <= {req.sx.neg, req.cx.neg, req.sy.neg, req.cy.neg, req.sz.neg, req.cz.neg};

        sx1_reg <= apply_sign(d_sx, neg_reg[5]);
        cx1_reg <= apply_sign(d_cx, neg_reg[4]);
        sy1_reg <= apply_sign(d_sy, neg_reg[3]);
        cy1_reg <= apply_sign(d_cy, neg_reg[2]);
        sz1_reg <= apply_sign(d_sz, neg_reg[1]);
        cz1_reg <= apply_sign(d_cz, neg_reg[0]);

        // first multiplier rank
        p_cycz_reg <= PROD_W'(cy1_reg) * PROD_W'(cz1_reg);
        p_cysz_reg <= PROD_W'(cy1_reg) * PROD_W'(sz1_reg);
        p_cxsz_reg <= PROD_W'(cx1_reg) * PROD_W'(sz1_reg);
        p_cxcz_reg <= PROD_W'(cx1_reg) * PROD_W'(cz1_reg);
        p_sxcy_reg <= PROD_W'(sx1_reg) * PROD_W'(cy1_reg);
        p_sxsz_reg <= PROD_W'(sx1_reg) * PROD_W'(sz1_reg);
        p_sxcz_reg <= PROD_W'(sx1_reg) * PROD_W'(cz1_reg);
        p_cxcy_reg <= PROD_W'(cx1_reg) * PROD_W'(cy1_reg);
        p_t1_reg   <= PROD_W'(sy1_reg) * PROD_W'(cz1_reg);
        p_t2_reg   <= PROD_W'(sy1_reg) * PROD_W'(sz1_reg);
        sx2_reg    <= sx1_reg;
        cx2_reg    <= cx1_reg;
        sy2_reg    <= sy1_reg;

        // rescale; negated terms take the sign before the floor shift
        a00_3_reg <= shr(p_cycz_reg);
        a01_3_reg <= shr(-p_cysz_reg);
        a02_3_reg <= sy2_reg;
        a10_3_reg <= shr(p_cxsz_reg);
        a11_3_reg <= shr(p_cxcz_reg);
        a12_3_reg <= shr(-p_sxcy_reg);
        a20_3_reg <= shr(p_sxsz_reg);
        a21_3_reg <= shr(p_sxcz_reg);
        a22_3_reg <= shr(p_cxcy_reg);
        t1_reg    <= shr(p_t1_reg);
        t2_reg    <= shr(p_t2_reg);
        sx3_reg   <= sx2_reg;
        cx3_reg   <= cx2_reg;

        // second multiplier rank
        q10_reg   <= PROD_W'(sx3_reg) * PROD_W'(t1_reg);
        q11_reg   <= PROD_W'(sx3_reg) * PROD_W'(t2_reg);
        q20_reg   <= PROD_W'(cx3_reg) * PROD_W'(t1_reg);
        q21_reg   <= PROD_W'(cx3_reg) * PROD_W'(t2_reg);
        a00_4_reg <= a00_3_reg;
        a01_4_reg <= a01_3_reg;
        a02_4_reg <= a02_3_reg;
        a10_4_reg <= a10_3_reg;
        a11_4_reg <= a11_3_reg;
        a12_4_reg <= a12_3_reg;
        a20_4_reg <= a20_3_reg;
        a21_4_reg <= a21_3_reg;
        a22_4_reg <= a22_3_reg;
    end

    result_t res_in;

    always_comb
    begin
        res_in.r00 = to_field(ext(a00_4_reg));
        res_in.r01 = to_field(ext(a01_4_reg));
        res_in.r02 = to_field(ext(a02_4_reg));
        res_in.r10 = to_field(ext(a10_4_reg) + ext(shr(q10_reg)));
        res_in.r11 = to_field(ext(a11_4_reg) + ext(shr(-q11_reg)));
        res_in.r12 = to_field(ext(a12_4_reg));
        res_in.r20 = to_field(ext(a20_4_reg) + ext(shr(-q20_reg)));
        res_in.r21 = to_field(ext(a21_4_reg) + ext(shr(q21_reg)));
        res_in.r22 = to_field(ext(a22_4_reg));
    end

    // ---- control: valid shift line and credit check against the result queue ----
    logic [4:0]          vld_reg, vld_next;
    logic [CREDIT_W-1:0] inflight;
    logic [CREDIT_W-1:0] committed;

    result_t             oq_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] oq_wr_reg, oq_wr_next;
    logic [OQ_PTR_W-1:0] oq_rd_reg, oq_rd_next;
    logic [OQ_CNT_W-1:0] oq_cnt_reg, oq_cnt_next;
    logic                oq_write;
    logic                oq_read;

    assign inflight  = CREDIT_W'($countones(vld_reg));
    assign committed = CREDIT_W'(oq_cnt_reg) + inflight;
    assign req_take  = req_valid && (committed < CREDIT_W'(OQ_DEPTH));

    assign oq_write = vld_reg[4];
    assign empty    = (oq_cnt_reg == '0);
    assign oq_read  = pop && !empty;
    assign res      = oq_reg[oq_rd_reg];

    always_comb
    begin
        vld_next    = {vld_reg[3:0], req_take};
        oq_wr_next  = oq_write ? oq_wr_reg + 1'b1 : oq_wr_reg;
        oq_rd_next  = oq_read ? oq_rd_reg + 1'b1 : oq_rd_reg;
        oq_cnt_next = oq_cnt_reg + OQ_CNT_W'(oq_write) - OQ_CNT_W'(oq_read);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            vld_reg    <= vld_next;
            oq_wr_reg  <= oq_wr_next;
            oq_rd_reg  <= oq_rd_next;
            oq_cnt_reg <= oq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_write)
            oq_reg[oq_wr_reg] <= res_in;
    end

endmodule

`default_nettype wire

### rtl/euler_xyz_rotation_matrix_core.sv
// Top level of the Euler x-y-z rotation matrix core.
//
// Turns three binary angles (4096 = one full turn) into the row-major 3x3
// matrix R = Rx*Ry*Rz in Q1.14, every entry saturated to +/-1.0. Both sides
// behave as queues: a request goes in with push while full is low, and the
// oldest result sits on r00..r22 while empty is low, taken with pop. One
// request is taken every clock while the result queue has room for it. On
// its way to r00..r22 a request passes through the request queue register,
// the registered sine table reads (three two-port ROMs cover the six sine
// and cosine lookups), the sign stage, the first multiplier rank and its
// rescale stage, the second multiplier rank, and the write of the rescaled,
// summed and saturated entries into the result queue. A two-entry request
// queue and an eight-entry result queue let either side stall without
// losing work. No state is kept between requests.
`timescale 1ns / 1ps
`default_nettype none

module euler_xyz_rotation_matrix_core
    import eul_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    output logic                         full,
    input  wire logic [ANGLE_W-1:0]      angle_x,
    input  wire logic [ANGLE_W-1:0]      angle_y,
    input  wire logic [ANGLE_W-1:0]      angle_z,
    output logic                         empty,
    input  wire logic                    pop,
    output logic signed [OUT_W-1:0]      r00,
    output logic signed [OUT_W-1:0]      r01,
    output logic signed [OUT_W-1:0]      r02,
    output logic signed [OUT_W-1:0]      r10,
    output logic signed [OUT_W-1:0]      r11,
    output logic signed [OUT_W-1:0]      r12,
    output logic signed [OUT_W-1:0]      r20,
    output logic signed [OUT_W-1:0]      r21,
    output logic signed [OUT_W-1:0]      r22
);

    logic      req_valid;
    logic      req_take;
    trig_req_t req;
    result_t   res;

    eul_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .angle_x   (angle_x),
        .angle_y   (angle_y),
        .angle_z   (angle_z),
        .req_valid (req_valid),
        .req       (req),
        .req_take  (req_take)
    );

    eul_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_take  (req_take),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign r00 = $signed(res.r00);
    assign r01 = $signed(res.r01);
    assign r02 = $signed(res.r02);
    assign r10 = $signed(res.r10);
    assign r11 = $signed(res.r11);
    assign r12 = $signed(res.r12);
    assign r20 = $signed(res.r20);
    assign r21 = $signed(res.r21);
    assign r22 = $signed(res.r22);

endmodule

`default_nettype wire
